/* rtl/core/swsb_pkg.sv */
// ----------------------------------------------------------------------------
// swsb_pkg
// Shared types and constants for the sliding window stride buffer.
// ----------------------------------------------------------------------------
package swsb_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int POS_W       = 5;
	localparam int HOP_W       = 5;
	localparam int NEW_W       = 6;

	localparam logic [NEW_W-1:0] NEW_MAX   = 6'd63;
	localparam logic [HOP_W-1:0] HOP_RESET = 5'd10;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t accel_x;
		sample_t accel_y;
		sample_t accel_z;
		sample_t gyro_x;
		sample_t gyro_y;
		sample_t gyro_z;
	} in_item_t;

	typedef struct packed {
		sample_t          out_accel_x;
		sample_t          out_accel_y;
		sample_t          out_accel_z;
		sample_t          out_gyro_x;
		sample_t          out_gyro_y;
		sample_t          out_gyro_z;
		logic [POS_W-1:0] position;
		logic             last_of_window;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic recirc;
		logic out_load;
	} chain_ctl_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             last_of_window;
	} out_tag_t;

endpackage

/* rtl/core/sliding_window_stride_buffer_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_stride_buffer_top
// Sliding window of six-axis motion samples, emitted whole on a stride.
// ----------------------------------------------------------------------------
// Samples enter a chain of WINDOW cells, oldest at the head. A sample that
// does not complete a window is taken without a stall. One that fills the
// window for the first time, or brings the new-sample count up to hop_length,
// starts a read-out: the chain recirculates once, one cell per cycle unless
// out_stall holds results back, through the single read tap at its head,
// in_stall staying high throughout, and the window leaves oldest first,
// last_of_window marking the newest sample. There is no clearing pass after
// reset; the user writes hop_length only while idle, which is not enforced.
// ----------------------------------------------------------------------------
module sliding_window_stride_buffer_top
	import swsb_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [HOP_W-1:0] cfg_wr_data
);

	chain_ctl_t ctl;
	out_tag_t   tag;
	in_item_t   chain [WINDOW];
	in_item_t   tail_in;
	in_item_t   head_q;

	swsb_ctrl #(
		.WINDOW(WINDOW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ctl        (ctl),
		.tag        (tag)
	);

	// tail takes a new sample, or the head while recirculating
	assign tail_in = ctl.recirc ? chain[0] : in_data;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == WINDOW - 1) begin : g_tail
			swsb_cell u_cell (
				.clk  (clk),
				.shift(ctl.shift),
				.nbr  (tail_in),
				.data (chain[i])
			);
		end else begin : g_body
			swsb_cell u_cell (
				.clk  (clk),
				.shift(ctl.shift),
				.nbr  (chain[i+1]),
				.data (chain[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			head_q <= chain[0];
		end
	end

	assign out_data.out_accel_x    = head_q.accel_x;
	assign out_data.out_accel_y    = head_q.accel_y;
	assign out_data.out_accel_z    = head_q.accel_z;
	assign out_data.out_gyro_x     = head_q.gyro_x;
	assign out_data.out_gyro_y     = head_q.gyro_y;
	assign out_data.out_gyro_z     = head_q.gyro_z;
	assign out_data.position       = tag.position;
	assign out_data.last_of_window = tag.last_of_window;

	// mid-window results only while a read-out holds off new samples
	a_midwin_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_of_window |-> in_stall)
		else $error("window read-out not holding off input");

	// taking a mid-window result brings the next position straight away
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_of_window |=>
		out_valid && (out_data.position == POS_W'($past(out_data.position) + 1'b1)))
		else $error("window positions not consecutive");

	// last marker sits on the final position of the window
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_of_window |-> out_data.position == POS_W'(WINDOW - 1))
		else $error("last_of_window on wrong position");

	// a read-out starts only from an accepted transaction
	a_busy_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("read-out started without an input transaction");

endmodule

/* rtl/core/swsb_cell.sv */
// ----------------------------------------------------------------------------
// swsb_cell
// One window slot: holds a six-axis sample and takes its neighbor's on shift.
// ----------------------------------------------------------------------------
module swsb_cell
	import swsb_pkg::*;
(
	input  logic     clk,
	input  logic     shift,
	input  in_item_t nbr,
	output in_item_t data
);

	in_item_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= nbr;
		end
	end

	assign data = data_q;

endmodule

/* rtl/core/swsb_ctrl.sv */
// ----------------------------------------------------------------------------
// swsb_ctrl
// Fill and hop counting, emit decision and read-out sequencing of the chain.
// ----------------------------------------------------------------------------
module swsb_ctrl
	import swsb_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  logic             cfg_wr_en,
	input  logic [HOP_W-1:0] cfg_wr_data,
	output chain_ctl_t       ctl,
	output out_tag_t         tag
);

	localparam int CNT_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WINDOW - 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [NEW_W-1:0]  new_q;
	logic              first_q;
	logic [HOP_W-1:0]  hop_q;
	logic              out_valid_q;
	out_tag_t          tag_q;

	logic              in_acc;
	logic              out_free;
	logic              rot;
	logic [FILL_W-1:0] fill_next;
	logic [NEW_W-1:0]  new_next;
	logic              emit;
	logic [CNT_W+POS_W-1:0] cnt_ext;

	assign in_acc   = in_valid && !busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign rot      = busy_q && out_free;

	assign fill_next = (fill_q == FILL_FULL) ? fill_q : fill_q + 1'b1;
	assign new_next  = (new_q == NEW_MAX) ? new_q : new_q + 1'b1;
	assign emit      = (fill_next == FILL_FULL) &&
		(!first_q || (new_next >= {1'b0, hop_q}));

	assign cnt_ext = {{POS_W{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			fill_q      <= '0;
			new_q       <= '0;
			first_q     <= 1'b0;
			hop_q       <= HOP_RESET;
			out_valid_q <= 1'b0;
			tag_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				hop_q <= cfg_wr_data;
			end
			if (in_acc) begin
				fill_q <= fill_next;
				if (emit) begin
					busy_q  <= 1'b1;
					first_q <= 1'b1;
					new_q   <= '0;
				end else begin
					new_q <= new_next;
				end
			end
			if (rot) begin
				out_valid_q          <= 1'b1;
				tag_q.position       <= cnt_ext[POS_W-1:0];
				tag_q.last_of_window <= (cnt_q == CNT_LAST);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign ctl.shift    = in_acc || rot;
	assign ctl.recirc   = busy_q;
	assign ctl.out_load = rot;

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign tag       = tag_q;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sliding window stride buffer. Motion samples are sent in
// random bursts under several hop settings, each emitted window is predicted
// from a local copy of the ring and every result transaction is checked field
// by field against it.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swsb_pkg::*;

	localparam int WINDOW        = 20;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 30;
	localparam int LONG_HOLD     = 120;

	typedef enum {PRESSURE_NONE, PRESSURE_HOLD, PRESSURE_PAUSE} pressure_t;

	class window_scoreboard;
		localparam int DEPTH = WINDOW;

		in_item_t         ring [DEPTH];
		int               wr_ptr;
		int               fill;
		logic [NEW_W-1:0] fresh;
		logic             first_done;
		logic [HOP_W-1:0] hop;
		out_item_t        window_q [$];
		int               errors;

		function new();
			wr_ptr     = 0;
			fill       = 0;
			fresh      = '0;
			first_done = 1'b0;
			hop        = HOP_RESET;
			errors     = 0;
		endfunction

		function void take_sample(in_item_t s);
			out_item_t r;
			int        src;
			ring[wr_ptr] = s;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			if (fill < DEPTH)
				fill++;
			if (fresh != NEW_MAX)
				fresh++;
			if (fill < DEPTH || (first_done && fresh < hop))
				return;
			// oldest sample sits at the write pointer
			for (int k = 0; k < DEPTH; k++) begin
				src = (wr_ptr + k) % DEPTH;
				r.out_accel_x    = ring[src].accel_x;
				r.out_accel_y    = ring[src].accel_y;
				r.out_accel_z    = ring[src].accel_z;
				r.out_gyro_x     = ring[src].gyro_x;
				r.out_gyro_y     = ring[src].gyro_y;
				r.out_gyro_z     = ring[src].gyro_z;
				r.position       = POS_W'(k);
				r.last_of_window = (k == DEPTH - 1);
				window_q.push_back(r);
			end
			first_done = 1'b1;
			fresh      = '0;
		endfunction

		function void compare_field(string name, logic [SAMPLE_BITS-1:0] want,
				logic [SAMPLE_BITS-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, actual %h",
					$time, name, want, got);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (window_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, actual %h",
					$time, got);
				return;
			end
			want = window_q.pop_front();
			compare_field("out_accel_x", want.out_accel_x, got.out_accel_x);
			compare_field("out_accel_y", want.out_accel_y, got.out_accel_y);
			compare_field("out_accel_z", want.out_accel_z, got.out_accel_z);
			compare_field("out_gyro_x", want.out_gyro_x, got.out_gyro_x);
			compare_field("out_gyro_y", want.out_gyro_y, got.out_gyro_y);
			compare_field("out_gyro_z", want.out_gyro_z, got.out_gyro_z);
			compare_field("position", SAMPLE_BITS'(want.position),
				SAMPLE_BITS'(got.position));
			compare_field("last_of_window", SAMPLE_BITS'(want.last_of_window),
				SAMPLE_BITS'(got.last_of_window));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_wr_en;
	logic [HOP_W-1:0] cfg_wr_data;

	window_scoreboard sb = new();

	int burst_left;
	bit sender_steady;
	bit hold_off_req;

	sliding_window_stride_buffer_top #(
		.WINDOW(WINDOW)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_sample(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	// receiver stall pattern, plus a long hold-off on request
	initial begin : receiver
		int   mode;
		int   stretch;
		int   hold_cnt;
		int   cyc;
		bit   hold_done;
		logic stall_now;
		out_stall = 1'b0;
		mode      = 0;
		stretch   = 0;
		hold_cnt  = 0;
		cyc       = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt  = LONG_HOLD;
			end
			if (stretch == 0) begin
				mode    = $urandom_range(0, 3);
				stretch = $urandom_range(10, 150);
			end
			stretch--;
			cyc++;
			case (mode)
				0: stall_now = 1'b0;
				1: stall_now = ($urandom_range(0, 3) == 0);
				2: stall_now = (cyc % 4 < 2);
				default: stall_now = ($urandom_range(0, 3) != 0);
			endcase
			if (hold_cnt != 0) begin
				stall_now = 1'b1;
				hold_cnt--;
			end
			out_stall <= stall_now;
		end
	end

	function automatic in_item_t corner_sample(int i);
		sample_t  c [6] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
			16'sh5555, 16'shAAAA};
		in_item_t s;
		s.accel_x = c[i % 6];
		s.accel_y = c[(i + 1) % 6];
		s.accel_z = c[(i + 2) % 6];
		s.gyro_x  = c[(i + 3) % 6];
		s.gyro_y  = c[(i + 4) % 6];
		s.gyro_z  = c[(i + 5) % 6];
		return s;
	endfunction

	function automatic sample_t random_value();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_sample();
		in_item_t s;
		s.accel_x = random_value();
		s.accel_y = random_value();
		s.accel_z = random_value();
		s.gyro_x  = random_value();
		s.gyro_y  = random_value();
		s.gyro_z  = random_value();
		return s;
	endfunction

	task automatic send_sample(in_item_t s);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap        = sender_steady ? 0 : $urandom_range(0, 8);
			burst_left = $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= s;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.window_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hop(logic [HOP_W-1:0] hop);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= hop;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.hop = hop;
	endtask

	task automatic run_phase(logic [HOP_W-1:0] hop, int count, pressure_t pressure);
		drain_results();
		write_hop(hop);
		sender_steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			if (pressure == PRESSURE_HOLD && i == 10)
				hold_off_req = 1'b1;
			if (pressure == PRESSURE_PAUSE && i == count / 2)
				drain_results();
			send_sample(random_sample());
		end
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		burst_left    = 0;
		sender_steady = 1'b0;
		hold_off_req  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset hop, first window and a few samples past it
		for (int i = 0; i < 25; i++)
			send_sample(corner_sample(i));

		run_phase(5'd1, 50, PRESSURE_NONE);
		run_phase(5'd20, 60, PRESSURE_PAUSE);
		run_phase(5'd0, 40, PRESSURE_HOLD);
		run_phase(5'd31, 80, PRESSURE_NONE);
		run_phase(HOP_W'($urandom_range(2, 19)), 50, PRESSURE_NONE);
		run_phase(HOP_W'($urandom_range(0, 31)), 50, PRESSURE_NONE);

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.window_q.size() == 0)
			$display("PASS sliding_window_stride_buffer_top");
		else
			$display("FAIL sliding_window_stride_buffer_top");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("FAIL sliding_window_stride_buffer_top");
		$finish;
	end

endmodule

/* sliding_window_stride_buffer_top.f */
rtl/core/swsb_pkg.sv
rtl/core/swsb_cell.sv
rtl/core/swsb_ctrl.sv
rtl/core/sliding_window_stride_buffer_top.sv
dv/tb_top.sv
